@@ hdl/jts_pkg.sv @@
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, character codes and keyword tables for the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

	// Default longest lexeme count before saturation
	localparam int MAX_LEXEME_DEF = 256;

	// Fixed field widths
	localparam int LEN_W  = 9;
	localparam int LINE_W = 24;
	localparam logic [LINE_W-1:0] LINE_MAX = '1;

	// Result queue depth (power of two, at least two)
	localparam int OUT_DEPTH = 4;

	// Characters of interest
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_E_LOW    = 8'h65;
	localparam logic [7:0] CH_E_UP     = 8'h45;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	// Keyword selector values
	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	typedef enum logic [3:0] {
		KIND_LBRACE   = 4'd0,
		KIND_RBRACE   = 4'd1,
		KIND_LBRACKET = 4'd2,
		KIND_RBRACKET = 4'd3,
		KIND_COLON    = 4'd4,
		KIND_COMMA    = 4'd5,
		KIND_STRING   = 4'd6,
		KIND_NUMBER   = 4'd7,
		KIND_TRUE     = 4'd8,
		KIND_FALSE    = 4'd9,
		KIND_NULL     = 4'd10,
		KIND_EOF      = 4'd11,
		KIND_ERROR    = 4'd12
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_TOO_LONG   = 3'd1,
		ERR_BAD_TRUE   = 3'd2,
		ERR_BAD_FALSE  = 3'd3,
		ERR_BAD_NULL   = 3'd4,
		ERR_UNEXPECTED = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_STRING  = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_KEYWORD = 3'd3,
		MODE_DONE    = 3'd4
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		err_t              code;
		logic [LINE_W-1:0] line;
		logic [LEN_W-1:0]  len;
		logic [7:0]        off;
		logic              last;
	} token_t;

	// Up to two results pushed per scanned byte
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	function automatic token_t mk_tok(kind_t kind, err_t code, logic [LINE_W-1:0] line,
		logic [LEN_W-1:0] len, logic [7:0] off);
		token_t t;
		t.kind = kind;
		t.code = code;
		t.line = line;
		t.len  = len;
		t.off  = off;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic logic [2:0] kw_len(logic [1:0] ch);
		logic [2:0] l;
		unique case (ch)
			KW_FALSE: l = 3'd5;
			default:  l = 3'd4;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(logic [1:0] ch, logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (ch)
			KW_FALSE: begin
				unique case (pos)
					3'd0:    c = 8'h66;
					3'd1:    c = 8'h61;
					3'd2:    c = 8'h6C;
					3'd3:    c = 8'h73;
					3'd4:    c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			KW_NULL: begin
				unique case (pos)
					3'd0:    c = 8'h6E;
					3'd1:    c = 8'h75;
					3'd2:    c = 8'h6C;
					3'd3:    c = 8'h6C;
					default: c = 8'h00;
				endcase
			end
			default: begin
				unique case (pos)
					3'd0:    c = 8'h74;
					3'd1:    c = 8'h72;
					3'd2:    c = 8'h75;
					3'd3:    c = 8'h65;
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

@@ hdl/jts_core.sv @@
// ----------------------------------------------------------------------------
// jts_core
// Input register, scanner state and the per-byte decision that yields up to
// two token results for each accepted byte.
// ----------------------------------------------------------------------------
module jts_core import jts_pkg::*; #(
	parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_input,
	input  logic       room,
	output push_t      push
);

	localparam int CLOG_W = $clog2(MAX_LEXEME + 1);
	localparam int CNT_W  = (CLOG_W > LEN_W) ? CLOG_W : LEN_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEXEME);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       adv;

	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_input;
		end
	end

	// Scanner state
	mode_t             mode_q, mode_d;
	logic [1:0]        choice_q, choice_d;
	logic [2:0]        pos_q, pos_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic [CNT_W-1:0]  lex_q, lex_d;
	logic              ovf_q, ovf_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			choice_q <= KW_TRUE;
			pos_q    <= '0;
			line_q   <= LINE_W'(1);
			lex_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (adv) begin
			mode_q   <= mode_d;
			choice_q <= choice_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			lex_q    <= lex_d;
			ovf_q    <= ovf_d;
		end
	end

	// Helpers shared by several modes
	logic [1:0]       ch;
	logic [2:0]       klen, kpos, kpos_inc;
	logic [CNT_W-1:0] cnt_up;
	logic [LEN_W-1:0] lex_len, up_len;
	logic             is_digit, is_numch;

	assign ch       = (choice_q == 2'd3) ? KW_TRUE : choice_q;
	assign klen     = kw_len(ch);
	assign kpos     = (pos_q < klen) ? pos_q : 3'(klen - 3'd1);
	assign kpos_inc = 3'(kpos + 3'd1);
	assign cnt_up   = (lex_q < CNT_MAX) ? CNT_W'(lex_q + CNT_ONE) : lex_q;
	assign lex_len  = lex_q[LEN_W-1:0];
	assign up_len   = cnt_up[LEN_W-1:0];
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_numch = is_digit || byte_s1 == CH_DOT || byte_s1 == CH_E_LOW
		|| byte_s1 == CH_E_UP;

	// Scan of a byte seen from idle
	logic              i_emit;
	token_t            i_tok;
	mode_t             i_mode;
	logic [1:0]        i_choice;
	logic [2:0]        i_pos;
	logic [LINE_W-1:0] i_line;
	logic [CNT_W-1:0]  i_lex;
	logic              i_ovf;

	always_comb begin
		i_emit   = 1'b0;
		i_tok    = '0;
		i_mode   = MODE_IDLE;
		i_choice = choice_q;
		i_pos    = pos_q;
		i_line   = line_q;
		i_lex    = lex_q;
		i_ovf    = ovf_q;
		if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB) begin
			i_emit = 1'b0;
		end else if (byte_s1 == CH_NL) begin
			if (line_q != LINE_MAX) begin
				i_line = LINE_W'(line_q + 1'b1);
			end
		end else if (byte_s1 == CH_QUOTE) begin
			i_mode = MODE_STRING;
			i_lex  = CNT_ONE;
			i_ovf  = 1'b0;
		end else if (is_digit || byte_s1 == CH_MINUS) begin
			i_mode = MODE_NUMBER;
			i_lex  = CNT_ONE;
		end else if (byte_s1 == CH_T || byte_s1 == CH_F || byte_s1 == CH_N) begin
			i_mode   = MODE_KEYWORD;
			i_choice = (byte_s1 == CH_T) ? KW_TRUE : (byte_s1 == CH_F) ? KW_FALSE : KW_NULL;
			i_pos    = 3'd1;
		end else begin
			i_emit = 1'b1;
			case (byte_s1)
				CH_LBRACE:   i_tok = mk_tok(KIND_LBRACE, ERR_NONE, line_q, '0, '0);
				CH_RBRACE:   i_tok = mk_tok(KIND_RBRACE, ERR_NONE, line_q, '0, '0);
				CH_LBRACKET: i_tok = mk_tok(KIND_LBRACKET, ERR_NONE, line_q, '0, '0);
				CH_RBRACKET: i_tok = mk_tok(KIND_RBRACKET, ERR_NONE, line_q, '0, '0);
				CH_COLON:    i_tok = mk_tok(KIND_COLON, ERR_NONE, line_q, '0, '0);
				CH_COMMA:    i_tok = mk_tok(KIND_COMMA, ERR_NONE, line_q, '0, '0);
				default:     i_tok = mk_tok(KIND_ERROR, ERR_UNEXPECTED, line_q, '0, byte_s1);
			endcase
		end
	end

	// Next state and results
	kind_t  kw_kind;
	err_t   kw_err;
	token_t eof_tok;

	assign kw_kind = kind_t'(4'(KIND_TRUE) + 4'(ch));
	assign kw_err  = err_t'(3'(ERR_BAD_TRUE) + 3'(ch));
	assign eof_tok = mk_tok(KIND_EOF, ERR_NONE, line_q, '0, '0);

	always_comb begin
		mode_d    = mode_q;
		choice_d  = choice_q;
		pos_d     = pos_q;
		line_d    = line_q;
		lex_d     = lex_q;
		ovf_d     = ovf_q;
		push      = '0;
		if (mode_q == MODE_DONE) begin
			// Only end marks answer after the end
			if (end_s1) begin
				push.cnt  = 2'd1;
				push.tok0 = eof_tok;
			end
		end else if (end_s1) begin
			// Flush what is pending, then eof
			unique case (mode_q)
				MODE_STRING: begin
					push.cnt  = 2'd2;
					push.tok0 = mk_tok(KIND_STRING, ERR_NONE, line_q, lex_len, '0);
					push.tok1 = eof_tok;
				end
				MODE_NUMBER: begin
					push.cnt  = 2'd2;
					push.tok0 = mk_tok(KIND_NUMBER, ERR_NONE, line_q, lex_len, '0);
					push.tok1 = eof_tok;
				end
				MODE_KEYWORD: begin
					push.cnt  = 2'd2;
					push.tok0 = mk_tok(KIND_ERROR, kw_err, line_q, '0, '0);
					push.tok1 = eof_tok;
				end
				default: begin
					push.cnt  = 2'd1;
					push.tok0 = eof_tok;
				end
			endcase
			mode_d = MODE_DONE;
			lex_d  = '0;
			pos_d  = '0;
		end else begin
			unique case (mode_q)
				MODE_STRING: begin
					lex_d = cnt_up;
					if (byte_s1 == CH_QUOTE) begin
						push.cnt  = 2'd1;
						push.tok0 = mk_tok(KIND_STRING, ERR_NONE, line_q, up_len, '0);
						mode_d    = MODE_IDLE;
					end else if (cnt_up >= CNT_MAX && !ovf_q) begin
						ovf_d     = 1'b1;
						push.cnt  = 2'd1;
						push.tok0 = mk_tok(KIND_ERROR, ERR_TOO_LONG, line_q, up_len, '0);
					end
				end
				MODE_NUMBER: begin
					if (is_numch) begin
						lex_d = cnt_up;
					end else begin
						// Number ends; the byte is scanned again from idle
						push.cnt  = i_emit ? 2'd2 : 2'd1;
						push.tok0 = mk_tok(KIND_NUMBER, ERR_NONE, line_q, lex_len, '0);
						push.tok1 = i_tok;
						mode_d    = i_mode;
						choice_d  = i_choice;
						pos_d     = i_pos;
						line_d    = i_line;
						lex_d     = i_lex;
						ovf_d     = i_ovf;
					end
				end
				MODE_KEYWORD: begin
					if (byte_s1 == kw_char(ch, kpos)) begin
						pos_d = kpos_inc;
						if (kpos_inc >= klen) begin
							push.cnt  = 2'd1;
							push.tok0 = mk_tok(kw_kind, ERR_NONE, line_q, '0, '0);
							mode_d    = MODE_IDLE;
							pos_d     = '0;
						end
					end else begin
						push.cnt  = 2'd1;
						push.tok0 = mk_tok(KIND_ERROR, kw_err, line_q, '0, byte_s1);
						mode_d    = MODE_IDLE;
						pos_d     = '0;
					end
				end
				default: begin
					push.cnt  = i_emit ? 2'd1 : 2'd0;
					push.tok0 = i_tok;
					mode_d    = i_mode;
					choice_d  = i_choice;
					pos_d     = i_pos;
					line_d    = i_line;
					lex_d     = i_lex;
					ovf_d     = i_ovf;
				end
			endcase
		end
		// Mark the final result of this byte
		if (push.cnt == 2'd2) begin
			push.tok1.last = 1'b1;
		end else begin
			push.tok0.last = 1'b1;
		end
		if (!adv) begin
			push.cnt = 2'd0;
		end
	end

endmodule

@@ hdl/jts_out_fifo.sv @@
// ----------------------------------------------------------------------------
// jts_out_fifo
// Small result queue: takes up to two tokens a cycle, hands out one a cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module jts_out_fifo import jts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	output logic   room,
	output logic   out_valid,
	input  logic   out_stall,
	output token_t head
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	token_t           mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign wr_nx     = PTR_W'(wr_q + 1'b1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= CNT_W'(OUT_DEPTH - 2));
	assign head      = mem_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PTR_W'(wr_q + push.cnt);
			cnt_q <= CNT_W'(cnt_q + push.cnt) - CNT_W'(pop);
			if (pop) begin
				rd_q <= PTR_W'(rd_q + 1'b1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_nx] <= push.tok1;
		end
	end

endmodule

@@ hdl/json_token_scanner.sv @@
// ----------------------------------------------------------------------------
// json_token_scanner
// Byte-serial JSON lexer: one text byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry text_byte and end_of_input; one
// beat per byte, end_of_input marks end of text and its byte is ignored.
// Output channel: out_valid / out_stall carry one token per beat, with
// last_result set on the final token caused by an input beat.
// Throughput: one byte per cycle while the input is not stalled. A byte that yields two tokens (a number
// closed by a punctuation byte, or an end mark that flushes a pending
// token) needs two output beats, so the output port sets the pace then.
// A token's byte is held in the input register; the scan logic then writes
// the token into the four-entry result queue, and the queue offers it.
// The input stalls while the queue has fewer than two free entries, and
// whenever the receiver stalls long enough to fill it; nothing is dropped.
// Reset (arst_n low) empties the queue, returns to idle with line 1 and
// clears the end-of-text mark; after an end mark only further end marks
// give results (eof) until reset.
// ----------------------------------------------------------------------------
module json_token_scanner import jts_pkg::*; #(
	parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        text_byte,
	input  logic              end_of_input,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        token_kind,
	output logic [2:0]        error_code,
	output logic [LINE_W-1:0] line_number,
	output logic [LEN_W-1:0]  lexeme_length,
	output logic [7:0]        offending_byte,
	output logic              last_result
);

	push_t  push;
	logic   room;
	token_t head;

	// Scanner
	jts_core #(
		.MAX_LEXEME(MAX_LEXEME)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_input(end_of_input),
		.room        (room),
		.push        (push)
	);

	// Result queue
	jts_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign token_kind     = head.kind;
	assign error_code     = head.code;
	assign line_number    = head.line;
	assign lexeme_length  = head.len;
	assign offending_byte = head.off;
	assign last_result    = head.last;

endmodule

@@ hdl/jts_checker.sv @@
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks for the JSON token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module jts_checker import jts_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [3:0]        token_kind,
	input logic [2:0]        error_code,
	input logic [LINE_W-1:0] line_number,
	input logic [LEN_W-1:0]  lexeme_length,
	input logic [7:0]        offending_byte,
	input logic              last_result
);

	// A stalled beat holds its token
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind)
		&& $stable(error_code) && $stable(line_number) && $stable(lexeme_length)
		&& $stable(offending_byte) && $stable(last_result))
		else $error("stalled output beat changed");

	// Error codes appear only on error tokens
	a_code_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != 4'(KIND_ERROR) |-> error_code == 3'(ERR_NONE))
		else $error("error code on a non-error token");

	// Eof always closes the results of its byte
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == 4'(KIND_EOF) |-> last_result)
		else $error("eof token without last_result");

	// Line numbers start at one and are never zero
	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != '0)
		else $error("line number zero");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.token_kind    (token_kind),
	.error_code    (error_code),
	.line_number   (line_number),
	.lexeme_length (lexeme_length),
	.offending_byte(offending_byte),
	.last_result   (last_result)
);

@@ bench/json_token_scanner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_scanner_tb
// Self-checking bench for the byte-serial JSON token scanner.
// A short table of hand-picked bytes comes first: punctuation, the byte
// extremes, a keyword failure, a string across a newline and a number closed
// by punctuation. Random well-formed JSON text with some noise follows, with
// long strings and numbers that hit the lexeme cap, and the run ends with an
// end mark in a random scan mode. Every accepted byte goes through a local
// scanner model; every token beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module json_token_scanner_tb;
	import jts_pkg::*;

	localparam int LEXEME_CAP   = MAX_LEXEME_DEF;
	localparam int ITEM_TARGET  = 1650;
	localparam int DRAIN_CYCLES = 20;
	// Allow several times the worst case (every byte with the longest gap and
	// two tokens behind the longest stall).
	localparam int LIMIT_NS     = 10_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        text_byte = 8'h00;
	logic              end_of_input = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [3:0]        token_kind;
	logic [2:0]        error_code;
	logic [LINE_W-1:0] line_number;
	logic [LEN_W-1:0]  lexeme_length;
	logic [7:0]        offending_byte;
	logic              last_result;

	json_token_scanner #(.MAX_LEXEME(LEXEME_CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.error_code(error_code),
		.line_number(line_number),
		.lexeme_length(lexeme_length),
		.offending_byte(offending_byte),
		.last_result(last_result)
	);

	// Directed table row; n_fixed < 0 means the scanner model decides
	typedef struct {
		logic [7:0] b;
		int         n_fixed;
		token_t     tok;
	} plan_row_t;

	plan_row_t plan[$];
	token_t    pending_tokens[$];
	token_t    step_tokens[$];
	int        mismatches = 0;
	int        beats_sent = 0;
	bit        sender_steady = 1'b0;
	bit        receiver_steady = 1'b0;
	int        stall_left = 0;

	// Scanner model state
	mode_t             scan_md = MODE_IDLE;
	logic [1:0]        word_sel = KW_TRUE;
	int                word_pos = 0;
	logic [LINE_W-1:0] line_cnt = LINE_W'(1);
	int                lex_cnt = 0;
	bit                too_long_seen = 1'b0;
	bit                text_done = 1'b0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scanner model
	// ------------------------------------------------------------------
	function automatic logic [7:0] word_letter(input logic [1:0] sel, input int pos);
		string w;
		case (sel)
			KW_TRUE:  w = "true";
			KW_FALSE: w = "false";
			default:  w = "null";
		endcase
		return (pos < w.len()) ? w[pos] : 8'h00;
	endfunction

	function automatic int word_size(input logic [1:0] sel);
		return (sel == KW_FALSE) ? 5 : 4;
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void add_token(input kind_t k, input err_t c, input int n,
		input logic [7:0] off);
		token_t t;
		t.kind = k;
		t.code = c;
		t.line = line_cnt;
		t.len  = n[LEN_W-1:0];
		t.off  = off;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void bump_length();
		if (lex_cnt < LEXEME_CAP)
			lex_cnt++;
	endfunction

	// A byte seen with nothing pending
	function automatic void scan_fresh(input logic [7:0] b);
		if (b == CH_SPACE || b == CH_TAB) begin
		end else if (b == CH_NL) begin
			if (line_cnt != LINE_MAX)
				line_cnt++;
		end else if (b == CH_QUOTE) begin
			scan_md = MODE_STRING;
			lex_cnt = 1;
			too_long_seen = 1'b0;
		end else if (is_digit(b) || b == CH_MINUS) begin
			scan_md = MODE_NUMBER;
			lex_cnt = 1;
		end else if (b == CH_T || b == CH_F || b == CH_N) begin
			scan_md = MODE_KEYWORD;
			word_sel = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
			word_pos = 1;
		end else begin
			case (b)
				CH_LBRACE:   add_token(KIND_LBRACE, ERR_NONE, 0, 8'h00);
				CH_RBRACE:   add_token(KIND_RBRACE, ERR_NONE, 0, 8'h00);
				CH_LBRACKET: add_token(KIND_LBRACKET, ERR_NONE, 0, 8'h00);
				CH_RBRACKET: add_token(KIND_RBRACKET, ERR_NONE, 0, 8'h00);
				CH_COLON:    add_token(KIND_COLON, ERR_NONE, 0, 8'h00);
				CH_COMMA:    add_token(KIND_COMMA, ERR_NONE, 0, 8'h00);
				default:     add_token(KIND_ERROR, ERR_UNEXPECTED, 0, b);
			endcase
		end
	endfunction

	// Tokens caused by one accepted beat go to step_tokens
	function automatic void scan_byte(input logic [7:0] b, input logic eoi);
		token_t t;
		step_tokens.delete();
		if (text_done) begin
			if (eoi)
				add_token(KIND_EOF, ERR_NONE, 0, 8'h00);
		end else if (eoi) begin
			case (scan_md)
				MODE_STRING:  add_token(KIND_STRING, ERR_NONE, lex_cnt, 8'h00);
				MODE_NUMBER:  add_token(KIND_NUMBER, ERR_NONE, lex_cnt, 8'h00);
				MODE_KEYWORD: add_token(KIND_ERROR, err_t'(ERR_BAD_TRUE + word_sel), 0, 8'h00);
				default: ;
			endcase
			add_token(KIND_EOF, ERR_NONE, 0, 8'h00);
			scan_md = MODE_DONE;
			text_done = 1'b1;
			lex_cnt = 0;
			word_pos = 0;
		end else begin
			case (scan_md)
				MODE_STRING: begin
					bump_length();
					if (b == CH_QUOTE) begin
						add_token(KIND_STRING, ERR_NONE, lex_cnt, 8'h00);
						scan_md = MODE_IDLE;
					end else if (lex_cnt >= LEXEME_CAP && !too_long_seen) begin
						too_long_seen = 1'b1;
						add_token(KIND_ERROR, ERR_TOO_LONG, lex_cnt, 8'h00);
					end
				end
				MODE_NUMBER: begin
					if (is_digit(b) || b == CH_DOT || b == CH_E_LOW || b == CH_E_UP) begin
						bump_length();
					end else begin
						// the closing byte is scanned again from idle
						add_token(KIND_NUMBER, ERR_NONE, lex_cnt, 8'h00);
						scan_md = MODE_IDLE;
						scan_fresh(b);
					end
				end
				MODE_KEYWORD: begin
					if (b == word_letter(word_sel, word_pos)) begin
						word_pos++;
						if (word_pos >= word_size(word_sel)) begin
							add_token(kind_t'(KIND_TRUE + word_sel), ERR_NONE, 0, 8'h00);
							scan_md = MODE_IDLE;
							word_pos = 0;
						end
					end else begin
						add_token(KIND_ERROR, err_t'(ERR_BAD_TRUE + word_sel), 0, b);
						scan_md = MODE_IDLE;
						word_pos = 0;
					end
				end
				default: begin
					scan_md = MODE_IDLE;
					scan_fresh(b);
				end
			endcase
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last = 1'b1;
			step_tokens.push_back(t);
		end
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One input beat; the expected tokens are queued at the accepting edge
	task automatic send_beat(input logic [7:0] b, input logic eoi, input int n_fixed,
		input token_t fixed_tok);
		int gap;
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		scan_byte(b, eoi);
		if (n_fixed < 0) begin
			foreach (step_tokens[i])
				pending_tokens.push_back(step_tokens[i]);
		end else if (n_fixed > 0) begin
			pending_tokens.push_back(fixed_tok);
		end
		if ($urandom_range(0, 119) == 0)
			sender_steady = !sender_steady;
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(b, 1'b0, -1, '0);
	endtask

	task automatic send_end();
		send_beat(8'($urandom_range(0, 255)), 1'b1, -1, '0);
	endtask

	function automatic logic [7:0] any_punct();
		case ($urandom_range(0, 5))
			0:       return CH_LBRACE;
			1:       return CH_RBRACE;
			2:       return CH_LBRACKET;
			3:       return CH_RBRACKET;
			4:       return CH_COLON;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] number_char();
		int r;
		r = $urandom_range(0, 12);
		if (r < 10)
			return CH_ZERO + r[7:0];
		if (r == 10)
			return CH_DOT;
		return (r == 11) ? CH_E_LOW : CH_E_UP;
	endfunction

	task automatic send_string(input int body);
		logic [7:0] b;
		send_byte(CH_QUOTE);
		repeat (body) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_QUOTE)
				b = CH_SPACE;
			send_byte(b);
		end
		send_byte(CH_QUOTE);
	endtask

	task automatic send_number(input int tail);
		send_byte(($urandom_range(0, 3) == 0) ? CH_MINUS
			: CH_ZERO + 8'($urandom_range(0, 9)));
		repeat (tail)
			send_byte(number_char());
	endtask

	// One random JSON token, mostly well formed
	task automatic send_random_token();
		int pick;
		int cut;
		logic [1:0] sel;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_byte(any_punct());
		end else if (pick < 32) begin
			case ($urandom_range(0, 2))
				0:       send_byte(CH_SPACE);
				1:       send_byte(CH_TAB);
				default: send_byte(CH_NL);
			endcase
		end else if (pick < 50) begin
			send_string(($urandom_range(0, 59) == 0) ? $urandom_range(250, 300)
				: $urandom_range(0, 8));
		end else if (pick < 70) begin
			send_number(($urandom_range(0, 59) == 0) ? $urandom_range(250, 300)
				: $urandom_range(0, 6));
		end else if (pick < 92) begin
			// keyword, sometimes broken at a random letter
			sel = 2'($urandom_range(0, 2));
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, word_size(sel) - 1)
				: word_size(sel);
			for (int i = 0; i < cut; i++)
				send_byte(word_letter(sel, i));
			if (cut < word_size(sel)) begin
				b = 8'($urandom_range(0, 255));
				if (b == word_letter(sel, cut))
					b = b ^ 8'h01;
				send_byte(b);
			end
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	function automatic void plan_fixed(input logic [7:0] b, input kind_t k, input err_t c,
		input logic [7:0] off);
		plan_row_t r;
		r.b = b;
		r.n_fixed = 1;
		r.tok = '{kind: k, code: c, line: 24'd1, len: '0, off: off, last: 1'b1};
		plan.push_back(r);
	endfunction

	function automatic void plan_quiet(input logic [7:0] b);
		plan_row_t r;
		r.b = b;
		r.n_fixed = 0;
		r.tok = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_free(input logic [7:0] b);
		plan_row_t r;
		r.b = b;
		r.n_fixed = -1;
		r.tok = '0;
		plan.push_back(r);
	endfunction

	function automatic void build_plan();
		// single tokens and extremes on line 1
		plan_fixed(CH_LBRACE, KIND_LBRACE, ERR_NONE, 8'h00);
		plan_fixed(CH_RBRACE, KIND_RBRACE, ERR_NONE, 8'h00);
		plan_fixed(CH_LBRACKET, KIND_LBRACKET, ERR_NONE, 8'h00);
		plan_fixed(CH_RBRACKET, KIND_RBRACKET, ERR_NONE, 8'h00);
		plan_fixed(CH_COLON, KIND_COLON, ERR_NONE, 8'h00);
		plan_fixed(CH_COMMA, KIND_COMMA, ERR_NONE, 8'h00);
		plan_fixed(8'hFF, KIND_ERROR, ERR_UNEXPECTED, 8'hFF);
		plan_fixed(8'h00, KIND_ERROR, ERR_UNEXPECTED, 8'h00);
		plan_quiet(CH_SPACE);
		// broken "true": failing byte is consumed
		plan_quiet(CH_T);
		plan_fixed(8'h58, KIND_ERROR, ERR_BAD_TRUE, 8'h58);
		plan_quiet(CH_NL);
		// string across a newline (not a new line)
		plan_free(CH_QUOTE);
		plan_free(CH_NL);
		plan_free(CH_QUOTE);
		// number closed by a bracket: two tokens
		plan_free(CH_MINUS);
		plan_free(CH_NINE);
		plan_free(CH_DOT);
		plan_free(CH_E_LOW);
		plan_free(CH_E_UP);
		plan_free(CH_RBRACKET);
		for (int i = 0; i < 4; i++)
			plan_free(word_letter(KW_NULL, i));
	endfunction

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			receiver_steady <= !receiver_steady;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (receiver_steady || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 2);
		end
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	// Token beat checker
	always @(posedge clk) begin
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				flag_mismatch($sformatf("token beat kind %0d with none expected", token_kind));
			end else begin
				want = pending_tokens.pop_front();
				if (token_kind !== want.kind)
					flag_mismatch($sformatf("token_kind %0d, want %0d", token_kind, want.kind));
				if (error_code !== want.code)
					flag_mismatch($sformatf("error_code %0d, want %0d", error_code, want.code));
				if (line_number !== want.line)
					flag_mismatch($sformatf("line_number %0d, want %0d", line_number, want.line));
				if (lexeme_length !== want.len)
					flag_mismatch($sformatf("lexeme_length %0d, want %0d", lexeme_length,
						want.len));
				if (offending_byte !== want.off)
					flag_mismatch($sformatf("offending_byte %02h, want %02h", offending_byte,
						want.off));
				if (last_result !== want.last)
					flag_mismatch($sformatf("last_result %0b, want %0b", last_result, want.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int ending;
		build_plan();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].b, 1'b0, plan[i].n_fixed, plan[i].tok);

		// hold off until every token so far has come out
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);

		// lexeme cap: string closing exactly at the cap, string past it, long number
		send_string(LEXEME_CAP - 2);
		send_string(300);
		send_number(279);
		send_byte(CH_COMMA);

		while (beats_sent < ITEM_TARGET)
			send_random_token();

		// close the text in a random scan mode
		ending = $urandom_range(0, 3);
		case (ending)
			1: begin
				send_byte(CH_QUOTE);
				send_byte(CH_ZERO);
			end
			2: begin
				send_byte(CH_MINUS);
				send_byte(CH_NINE);
			end
			3: begin
				send_byte(CH_N);
				send_byte(word_letter(KW_NULL, 1));
			end
			default: send_byte(CH_COMMA);
		endcase
		send_end();
		// text after the end mark is dropped; further end marks repeat eof
		repeat (3)
			send_byte(8'($urandom_range(0, 255)));
		repeat (2)
			send_end();

		in_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
